### rtl/pipw_pkg.sv
// shared constants and types for the winding-number point-in-polygon block
`timescale 1ns / 1ps

package pipw_pkg;

    // table depth and coordinate width
    localparam int MAX_VERTICES = 64;
    localparam int COORD_BITS   = 16;

    // step index and vertex count widths inside the block
    localparam int IDX_W = $clog2(MAX_VERTICES);
    localparam int CNT_W = $clog2(MAX_VERTICES + 1);

    // fixed port field widths
    localparam int VIDX_W = 6;
    localparam int VCNT_W = 7;

    // slave tdata layout, lowest bit first
    localparam int VIDX_LSB  = 0;
    localparam int CX_LSB    = VIDX_LSB + VIDX_W;
    localparam int CY_LSB    = CX_LSB + COORD_BITS;
    localparam int CHK_LSB   = CY_LSB + COORD_BITS;
    localparam int S_FIELD_W = CHK_LSB + 1;
    localparam int S_TDATA_W = ((S_FIELD_W + 7) / 8) * 8;

    // master tdata layout
    localparam int INS_BIT   = 0;
    localparam int ONB_BIT   = 1;
    localparam int M_TDATA_W = 8;

    // tuser code for the item kind
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // one vertex or point
    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
    } vtx_t;

    // one edge handed to the evaluation unit
    typedef struct packed {
        logic act;   // slot carries an edge step
        logic live;  // edge lies within the active vertex count
        logic lst;   // final step of the pass
        vtx_t a;
        vtx_t b;
    } edge_req_t;

    // evaluation result of one edge
    typedef struct packed {
        logic act;
        logic lst;
        logic on;    // point lies on the edge
        logic up;    // upward crossing, point left of edge
        logic dn;    // downward crossing, point right of edge
    } edge_res_t;

endpackage

### rtl/pipw_cell.sv
// one vertex cell of the rotating vertex ring
`timescale 1ns / 1ps

module pipw_cell
(
    input  logic           clk,
    input  logic           load_en,
    input  pipw_pkg::vtx_t load_vtx,
    input  logic           shift_en,
    input  pipw_pkg::vtx_t shift_vtx,
    output pipw_pkg::vtx_t vtx
);

    pipw_pkg::vtx_t vtx_reg;
    pipw_pkg::vtx_t vtx_next;

    // direct write from the stream, else take the neighbour's vertex
    always_comb
    begin
        vtx_next = vtx_reg;
        if (load_en)
        begin
            vtx_next = load_vtx;
        end
        else if (shift_en)
        begin
            vtx_next = shift_vtx;
        end
    end

    // vertex storage, undefined until written
    always_ff @(posedge clk)
    begin
        vtx_reg <= vtx_next;
    end

    assign vtx = vtx_reg;

endmodule

### rtl/pipw_edge.sv
// three-stage edge evaluation: crossing test and on-edge test for one edge a cycle
`timescale 1ns / 1ps

module pipw_edge
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  pipw_pkg::edge_req_t  req,
    input  pipw_pkg::vtx_t       pnt,
    output pipw_pkg::edge_res_t  res
);

    localparam int D_W = pipw_pkg::COORD_BITS + 1;
    localparam int P_W = 2 * D_W;
    localparam int C_W = P_W + 1;
    localparam int MSB = pipw_pkg::COORD_BITS - 1;

    // stage one: differences, ordering flags and extent check
    logic signed [D_W-1:0] ax_e, ay_e, bx_e, by_e, px_e, py_e;
    logic signed [D_W-1:0] lox, hix, loy, hiy;
    logic                  box_c;

    logic                  s1_act_reg, s1_lst_reg;
    logic                  s1_live_reg;
    logic signed [D_W-1:0] dxb_reg, dyp_reg, dxp_reg, dyb_reg;
    logic                  alo_reg, bhi_reg, box_reg;

    // stage two: products
    logic                  s2_act_reg, s2_lst_reg;
    logic                  s2_live_reg, s2_alo_reg, s2_bhi_reg, s2_box_reg;
    logic signed [P_W-1:0] p1_reg, p2_reg;

    // stage three: cross product sign
    logic signed [C_W-1:0] cr;
    logic                  cr_pos, cr_neg, cr_zero;
    pipw_pkg::edge_res_t   res_reg;
    pipw_pkg::edge_res_t   res_next;

    // sign extension by one bit
    assign ax_e = {req.a.x[MSB], req.a.x};
    assign ay_e = {req.a.y[MSB], req.a.y};
    assign bx_e = {req.b.x[MSB], req.b.x};
    assign by_e = {req.b.y[MSB], req.b.y};
    assign px_e = {pnt.x[MSB], pnt.x};
    assign py_e = {pnt.y[MSB], pnt.y};

    // edge extent
    always_comb
    begin
        lox   = (ax_e < bx_e) ? ax_e : bx_e;
        hix   = (ax_e < bx_e) ? bx_e : ax_e;
        loy   = (ay_e < by_e) ? ay_e : by_e;
        hiy   = (ay_e < by_e) ? by_e : ay_e;
        box_c = (px_e >= lox) && (px_e <= hix) && (py_e >= loy) && (py_e <= hiy);
    end

    // stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_act_reg <= 1'b0;
            s1_lst_reg <= 1'b0;
            s2_act_reg <= 1'b0;
            s2_lst_reg <= 1'b0;
            res_reg    <= '0;
        end
        else
        begin
            s1_act_reg <= req.act;
            s1_lst_reg <= req.lst;
            s2_act_reg <= s1_act_reg;
            s2_lst_reg <= s1_lst_reg;
            res_reg    <= res_next;
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        s1_live_reg <= req.live;
        dxb_reg     <= bx_e - ax_e;
        dyp_reg     <= py_e - ay_e;
        dxp_reg     <= px_e - ax_e;
        dyb_reg     <= by_e - ay_e;
        alo_reg     <= (ay_e <= py_e);
        bhi_reg     <= (by_e > py_e);
        box_reg     <= box_c;

        s2_live_reg <= s1_live_reg;
        s2_alo_reg  <= alo_reg;
        s2_bhi_reg  <= bhi_reg;
        s2_box_reg  <= box_reg;
        p1_reg      <= dxb_reg * dyp_reg;
        p2_reg      <= dxp_reg * dyb_reg;
    end

    // cross product and per-edge decisions
    always_comb
    begin
        cr      = {p1_reg[P_W-1], p1_reg} - {p2_reg[P_W-1], p2_reg};
        cr_zero = (cr == '0);
        cr_neg  = cr[C_W-1];
        cr_pos  = !cr_neg && !cr_zero;

        res_next     = '0;
        res_next.act = s2_act_reg;
        res_next.lst = s2_lst_reg;
        res_next.on  = s2_act_reg && s2_live_reg && s2_box_reg && cr_zero;
        res_next.up  = s2_act_reg && s2_live_reg && s2_alo_reg && s2_bhi_reg && cr_pos;
        res_next.dn  = s2_act_reg && s2_live_reg && !s2_alo_reg && !s2_bhi_reg && cr_neg;
    end

    assign res = res_reg;

endmodule

### rtl/point_in_polygon_winding.sv
// top level: vertex ring, pass sequencer, winding accumulator and output register
// query path: 64 ring steps through the 3-stage edge unit, then the finish into the output register
// a query holds off the input stream until its result is registered for output; each pass rotates the 64-cell ring once
// vertex writes are accepted only while idle and give no result
// reset: asynchronous, clears the sequencer, output valid and vertex_count; the table is not cleared
`timescale 1ns / 1ps

module point_in_polygon_winding
(
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration: vertex_count
    input  logic                              cfg_wr_en,
    input  logic [pipw_pkg::VCNT_W-1:0]       cfg_wr_data,
    // input stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // fields from bit 0: vertex_index[5:0], coord_x[21:6], coord_y[37:22], check_edges[38]
    input  logic [pipw_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    // fields from bit 0: func
    input  logic                              s_axis_tuser,
    // result stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // fields from bit 0: inside_res, on_boundary
    output logic [pipw_pkg::M_TDATA_W-1:0]    m_axis_tdata
);

    localparam int MAXV  = pipw_pkg::MAX_VERTICES;
    localparam int IDX_W = pipw_pkg::IDX_W;
    localparam int CNT_W = pipw_pkg::CNT_W;
    localparam int CB    = pipw_pkg::COORD_BITS;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [pipw_pkg::VCNT_W-1:0] vcnt_reg;
    logic [CNT_W-1:0]      n_lim;

    logic [IDX_W-1:0]      step_reg, step_next;
    pipw_pkg::vtx_t        pnt_reg, v0_reg;
    logic                  chk_reg;
    logic signed [CNT_W:0] wind_reg, wind_next;
    logic                  hit_reg, hit_next;
    logic                  ins_reg, onb_reg;

    logic                  m_valid_reg;
    logic [pipw_pkg::M_TDATA_W-1:0] m_data_reg, m_data_next;

    // unpacked input fields
    logic [pipw_pkg::VIDX_W-1:0] in_vidx;
    pipw_pkg::vtx_t        in_vtx;
    logic                  in_chk;
    logic                  in_xfer, wr_xfer, qry_xfer;

    // ring
    pipw_pkg::vtx_t        ring [MAXV];
    logic                  shift_en;

    pipw_pkg::edge_req_t   req;
    pipw_pkg::edge_res_t   res;
    logic                  finish, out_free;

    assign in_vidx  = s_axis_tdata[pipw_pkg::VIDX_LSB +: pipw_pkg::VIDX_W];
    assign in_vtx.x = s_axis_tdata[pipw_pkg::CX_LSB +: CB];
    assign in_vtx.y = s_axis_tdata[pipw_pkg::CY_LSB +: CB];
    assign in_chk   = s_axis_tdata[pipw_pkg::CHK_LSB];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign wr_xfer  = in_xfer && (s_axis_tuser == pipw_pkg::FUNC_WRITE);
    assign qry_xfer = in_xfer && (s_axis_tuser == pipw_pkg::FUNC_QUERY);
    assign shift_en = (state_reg == ST_SCAN);

    // active vertex count, clamped to the table depth
    assign n_lim = (vcnt_reg > MAXV) ? CNT_W'(MAXV) : CNT_W'(vcnt_reg);

    // vertex ring: each cell takes its upper neighbour while scanning
    for (genvar i = 0; i < MAXV; i++)
    begin : g_ring
        pipw_cell u_cell
        (
            .clk       (clk),
            .load_en   (wr_xfer && (int'(in_vidx) == i)),
            .load_vtx  (in_vtx),
            .shift_en  (shift_en),
            .shift_vtx (ring[(i + 1) % MAXV]),
            .vtx       (ring[i])
        );
    end

    // edge at the head of the ring, closing edge wraps to the first vertex
    always_comb
    begin
        req      = '0;
        req.act  = shift_en;
        req.live = ({1'b0, step_reg} < n_lim);
        req.lst  = (step_reg == IDX_W'(MAXV - 1));
        req.a    = ring[0];
        req.b    = ({1'b0, step_reg} == (n_lim - 1'b1)) ? v0_reg : ring[1];
    end

    pipw_edge u_edge
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .pnt   (pnt_reg),
        .res   (res)
    );

    assign finish   = res.act && res.lst;
    assign out_free = !m_valid_reg || m_axis_tready;

    // winding sum and edge hit
    always_comb
    begin
        wind_next = wind_reg;
        hit_next  = hit_reg;
        if (qry_xfer)
        begin
            wind_next = '0;
            hit_next  = 1'b0;
        end
        else if (res.act)
        begin
            wind_next = wind_reg + (res.up ? (CNT_W+1)'(1) : '0)
                                 - (res.dn ? (CNT_W+1)'(1) : '0);
            hit_next  = hit_reg || res.on;
        end
    end

    // pass sequencer
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            ST_IDLE:
            begin
                step_next = '0;
                if (qry_xfer)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == IDX_W'(MAXV - 1))
                begin
                    step_next  = '0;
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (finish)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                step_next  = '0;
            end
        endcase
    end

    // result word
    always_comb
    begin
        m_data_next                    = '0;
        m_data_next[pipw_pkg::INS_BIT] = ins_reg;
        m_data_next[pipw_pkg::ONB_BIT] = onb_reg;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            step_reg    <= '0;
            vcnt_reg    <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            if (cfg_wr_en)
            begin
                vcnt_reg <= cfg_wr_data;
            end
            if ((state_reg == ST_DONE) && out_free)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // query payload, accumulator and result
    always_ff @(posedge clk)
    begin
        if (qry_xfer)
        begin
            pnt_reg <= in_vtx;
            chk_reg <= in_chk;
            v0_reg  <= ring[0];
        end
        wind_reg <= wind_next;
        hit_reg  <= hit_next;
        if (finish)
        begin
            ins_reg <= (n_lim >= CNT_W'(3)) && ((chk_reg && hit_next) || (wind_next != '0));
            onb_reg <= (n_lim >= CNT_W'(3)) && chk_reg && hit_next;
        end
        if ((state_reg == ST_DONE) && out_free)
        begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    // a boundary hit always reports inside
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (!m_axis_tdata[pipw_pkg::ONB_BIT] || m_axis_tdata[pipw_pkg::INS_BIT]))
        else $error("on_boundary without inside_res");

    // ring is aligned whenever the block is idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (step_reg == '0))
        else $error("ring step not zero in idle");

    // the pass marker leaves the edge unit only while draining
    assert property (@(posedge clk) disable iff (!rst_n)
        finish |-> (state_reg == ST_DRAIN))
        else $error("pass end outside drain");

    // edge unit idle outside a pass
    assert property (@(posedge clk) disable iff (!rst_n)
        res.act |-> (state_reg == ST_SCAN || state_reg == ST_DRAIN))
        else $error("edge result outside a pass");

    // one-hot sequencer state
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("sequencer state not one-hot");

endmodule
